>>> rtl/bmpm_pkg.sv
// Package for the binary multi-pattern matcher: sizes, action and status codes,
// and the result record passed from the engine to the top level. No dependencies.
`timescale 1ns / 1ps
package bmpm_pkg;
    localparam int MAX_NODES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = NODE_W + 1;
    localparam int HITS_W    = 13;
    localparam int TOTAL_W   = 32;

    typedef logic [NODE_W-1:0] node_t;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic [HITS_W-1:0]  hits;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         status;
    } result_t;
endpackage

>>> rtl/bmpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bmpm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/bmpm_engine.sv
// Sequencer of the matcher: trie insert, breadth-first build, query walk and clear,
// all through one read port per table. Depends on bmpm_pkg and bmpm_ram.
`timescale 1ns / 1ps
module bmpm_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       action,
    input  logic             symbol,
    input  logic             last,
    input  logic             first,
    output logic             idle,
    input  logic             res_ready,
    output logic             res_valid,
    output bmpm_pkg::result_t res
);
    import bmpm_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_INS_RD, S_INS_WR, S_CPY, S_ROOT_RD, S_ROOT0, S_ROOT1,
        S_POP, S_U, S_F, S_WR0, S_WR1, S_QRD, S_QW, S_QS, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    logic [COUNT_W-1:0] head_reg, head_next, tail_reg, tail_next;
    node_t ins_cur_reg, ins_cur_next, match_reg, match_next;
    node_t u_reg, u_next, f_reg, f_next, t_reg, t_next;
    node_t gu0_reg, gu0_next, gu1_reg, gu1_next;
    logic dropped_reg, dropped_next;
    logic sym_reg, sym_next, last_reg, last_next;
    logic [HITS_W-1:0] hits_reg, hits_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [1:0] status_reg, status_next;

    logic trie_we, goto_we, fail_we, end_we, q_we;
    node_t trie_wa, trie_ra, goto_wa, goto_ra, fail_wa, fail_ra, end_wa, end_ra;
    node_t q_wa, q_ra, fail_wd, q_wd, fail_rd, q_rd;
    logic [2*NODE_W-1:0] trie_wd, trie_rd, goto_wd, goto_rd;
    logic end_wd, end_rd;

    bmpm_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_NODES)) u_trie (.clk(clk), .we(trie_we),
        .waddr(trie_wa), .wdata(trie_wd), .raddr(trie_ra), .rdata(trie_rd));
    bmpm_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_NODES)) u_goto (.clk(clk), .we(goto_we),
        .waddr(goto_wa), .wdata(goto_wd), .raddr(goto_ra), .rdata(goto_rd));
    bmpm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (.clk(clk), .we(fail_we),
        .waddr(fail_wa), .wdata(fail_wd), .raddr(fail_ra), .rdata(fail_rd));
    bmpm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_end (.clk(clk), .we(end_we),
        .waddr(end_wa), .wdata(end_wd), .raddr(end_ra), .rdata(end_rd));
    bmpm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (.clk(clk), .we(q_we),
        .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    node_t ch_sel, gf_sel, gu_sel;
    logic [TOTAL_W:0] sum;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        node_count_next = node_count_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ins_cur_next = ins_cur_reg;
        match_next = match_reg;
        u_next = u_reg;
        f_next = f_reg;
        t_next = t_reg;
        gu0_next = gu0_reg;
        gu1_next = gu1_reg;
        dropped_next = dropped_reg;
        sym_next = sym_reg;
        last_next = last_reg;
        hits_next = hits_reg;
        total_next = total_reg;
        status_next = status_reg;
        trie_we = 1'b0; goto_we = 1'b0; fail_we = 1'b0; end_we = 1'b0; q_we = 1'b0;
        trie_wa = idx_reg[NODE_W-1:0]; trie_wd = '0; trie_ra = ins_cur_reg;
        goto_wa = idx_reg[NODE_W-1:0]; goto_wd = '0; goto_ra = '0;
        fail_wa = idx_reg[NODE_W-1:0]; fail_wd = '0; fail_ra = u_reg;
        end_wa = idx_reg[NODE_W-1:0];  end_wd = 1'b0; end_ra = t_reg;
        q_wa = tail_reg[NODE_W-1:0];   q_wd = '0; q_ra = head_reg[NODE_W-1:0];
        ch_sel = sym_reg ? trie_rd[2*NODE_W-1:NODE_W] : trie_rd[NODE_W-1:0];
        gf_sel = '0;
        gu_sel = '0;
        sum = {1'b0, total_reg} + {{(TOTAL_W+1-HITS_W){1'b0}}, hits_reg};

        case (state_reg)
            S_CLR:
            begin
                trie_we = 1'b1; goto_we = 1'b1; fail_we = 1'b1; end_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == COUNT_W'(MAX_NODES - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    sym_next = symbol;
                    last_next = last;
                    hits_next = '0;
                    status_next = ST_OK;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (dropped_reg)
                            begin
                                status_next = ST_FULL;
                                if (last)
                                begin
                                    ins_cur_next = '0;
                                    dropped_next = 1'b0;
                                end
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_BUILD:
                        begin
                            status_next = ST_DONE;
                            idx_next = '0;
                            head_next = '0;
                            tail_next = '0;
                            state_next = S_CPY;
                        end
                        ACT_QUERY:
                        begin
                            if (first)
                            begin
                                match_next = '0;
                                total_next = '0;
                            end
                            state_next = S_QRD;
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                            idx_next = '0;
                            node_count_next = '0;
                            ins_cur_next = '0;
                            match_next = '0;
                            total_next = '0;
                            dropped_next = 1'b0;
                            state_next = S_CLR;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                if (ch_sel == '0 && node_count_reg >= COUNT_W'(MAX_NODES - 1))
                begin
                    status_next = ST_FULL;
                    dropped_next = !last_reg;
                    ins_cur_next = last_reg ? '0 : ins_cur_reg;
                end
                else
                begin
                    if (ch_sel == '0)
                    begin
                        node_count_next = node_count_reg + 1'b1;
                        ch_sel = node_count_next[NODE_W-1:0];
                        trie_we = 1'b1;
                        trie_wa = ins_cur_reg;
                        trie_wd = sym_reg ? {ch_sel, trie_rd[NODE_W-1:0]}
                                          : {trie_rd[2*NODE_W-1:NODE_W], ch_sel};
                    end
                    end_we = last_reg;
                    end_wa = ch_sel;
                    end_wd = 1'b1;
                    ins_cur_next = last_reg ? '0 : ch_sel;
                end
                state_next = S_DONE;
            end
            S_CPY:
            begin
                // Read trie entry idx, write the previous entry into the goto table.
                trie_ra = idx_reg[NODE_W-1:0];
                goto_we = (idx_reg != '0);
                goto_wa = NODE_W'(idx_reg - 1'b1);
                goto_wd = trie_rd;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == COUNT_W'(MAX_NODES))
                begin
                    state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                goto_ra = '0;
                state_next = S_ROOT0;
            end
            S_ROOT0, S_ROOT1:
            begin
                if (state_reg == S_ROOT0)
                begin
                    gu0_next = goto_rd[NODE_W-1:0];
                    gu1_next = goto_rd[2*NODE_W-1:NODE_W];
                    gu_sel = goto_rd[NODE_W-1:0];
                    state_next = S_ROOT1;
                end
                else
                begin
                    gu_sel = gu1_reg;
                    state_next = S_POP;
                end
                if (gu_sel != '0)
                begin
                    fail_we = 1'b1;
                    fail_wa = gu_sel;
                    fail_wd = '0;
                    q_we = 1'b1;
                    q_wd = gu_sel;
                    tail_next = tail_reg + 1'b1;
                end
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next = head_reg + 1'b1;
                    state_next = S_U;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_U:
            begin
                u_next = q_rd;
                fail_ra = q_rd;
                goto_ra = q_rd;
                state_next = S_F;
            end
            S_F:
            begin
                f_next = fail_rd;
                gu0_next = goto_rd[NODE_W-1:0];
                gu1_next = goto_rd[2*NODE_W-1:NODE_W];
                goto_ra = fail_rd;
                state_next = S_WR0;
            end
            S_WR0, S_WR1:
            begin
                gu_sel = (state_reg == S_WR0) ? gu0_reg : gu1_reg;
                gf_sel = (state_reg == S_WR0) ? goto_rd[NODE_W-1:0]
                                              : goto_rd[2*NODE_W-1:NODE_W];
                if (gu_sel != '0)
                begin
                    fail_we = 1'b1;
                    fail_wa = gu_sel;
                    fail_wd = gf_sel;
                    if (tail_reg < COUNT_W'(MAX_NODES))
                    begin
                        q_we = 1'b1;
                        q_wd = gu_sel;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                else
                begin
                    gu_sel = gf_sel;
                end
                if (state_reg == S_WR0)
                begin
                    gu0_next = gu_sel;
                    goto_ra = f_reg;
                    state_next = S_WR1;
                end
                else
                begin
                    goto_we = 1'b1;
                    goto_wa = u_reg;
                    goto_wd = {gu_sel, gu0_reg};
                    state_next = S_POP;
                end
            end
            S_QRD:
            begin
                goto_ra = match_reg;
                state_next = S_QW;
            end
            S_QW:
            begin
                t_next = sym_reg ? goto_rd[2*NODE_W-1:NODE_W] : goto_rd[NODE_W-1:0];
                match_next = t_next;
                end_ra = t_next;
                fail_ra = t_next;
                state_next = (t_next == '0) ? S_DONE : S_QS;
            end
            S_QS:
            begin
                hits_next = hits_reg + {{(HITS_W-1){1'b0}}, end_rd};
                t_next = fail_rd;
                end_ra = fail_rd;
                fail_ra = fail_rd;
                state_next = (fail_rd == '0) ? S_DONE : S_QS;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Saturating accumulate as the query result leaves.
        if (state_reg == S_QW || state_reg == S_QS)
        begin
            if (state_next == S_DONE)
            begin
                sum = {1'b0, total_reg} + {{(TOTAL_W+1-HITS_W){1'b0}}, hits_next};
                total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg <= '0;
            node_count_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            ins_cur_reg <= '0;
            match_reg <= '0;
            dropped_reg <= 1'b0;
            total_reg <= '0;
            hits_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            node_count_reg <= node_count_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            ins_cur_reg <= ins_cur_next;
            match_reg <= match_next;
            dropped_reg <= dropped_next;
            total_reg <= total_next;
            hits_reg <= hits_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        f_reg <= f_next;
        t_reg <= t_next;
        gu0_reg <= gu0_next;
        gu1_reg <= gu1_next;
        sym_reg <= sym_next;
        last_reg <= last_next;
    end

    // The reset sweep reports nothing; every action taken after it leaves a result.
    logic reported_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
        end
        else if (state_reg == S_IDLE)
        begin
            reported_reg <= 1'b1;
        end
    end

    assign idle = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE) && reported_reg;
    assign res.hits = hits_reg;
    assign res.total = total_reg;
    assign res.status = status_reg;

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= COUNT_W'(MAX_NODES - 1))
        else $error("node count beyond trie size");
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    a_hits_query: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hits_reg != '0 |-> status_reg == ST_OK)
        else $error("hits reported on a non-query beat");
endmodule

>>> rtl/binary_multi_pattern_matcher_top.sv
// Top level of the binary multi-pattern matcher: handshakes and result register.
// Depends on bmpm_pkg and bmpm_engine.
`timescale 1ns / 1ps
// Sequencing: insert, query, build and clear each run as a state sequence; a query also
// walks the failure chain and a build visits each trie node, all through one table read
// port per table.
// Throughput: one beat in flight at a time; the next beat is taken once the engine
// is idle, even while the previous result still waits in the output register.
// Reset: asynchronous, active low; afterwards a pass zeroes all 4096 table entries
// and in_ready stays low until that pass ends.
module binary_multi_pattern_matcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic        symbol,
    input  logic        last,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [12:0] hits,
    output logic [31:0] total,
    output logic [1:0]  status
);
    import bmpm_pkg::*;

    logic    eng_idle, res_valid, res_ready;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    // The result register frees its slot in the same cycle it is drained.
    assign res_ready = !out_valid_reg || out_ready;

    bmpm_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .start(in_valid && in_ready),
        .action(action), .symbol(symbol), .last(last), .first(first),
        .idle(eng_idle),
        .res_ready(res_ready), .res_valid(res_valid), .res(res)
    );

    assign in_ready = eng_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign hits = out_reg.hits;
    assign total = out_reg.total;
    assign status = out_reg.status;
endmodule
